### design/plst_pkg.sv
// Shared types and constants for the positional list store.
// Holds the request and response payloads and the controller/datapath interface.
`timescale 1ns / 1ps
`default_nettype none

package plst_pkg;

   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RETRIEVE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REPLACE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [POSITION_W-1:0] position;
      logic [VALUE_W-1:0]    value_in;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value_out;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic                is_full;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_AT_INDEX,
      RD_BELOW_INDEX,
      RD_ABOVE_INDEX
   } rd_sel_type;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_DEC,
      STEP_INC
   } step_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_from_mem;
      step_type   step;
      logic       save_result;
      logic       respond;
      cnt_op_type cnt_op;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                ok;
      logic                at_pos;
      logic                at_end;
   } stat_type;

endpackage

`default_nettype wire

### design/positional_list_store.sv
// Top level of the positional list store: controller and datapath joined by command/status.
// Depends on plst_pkg, plst_ctrl and plst_dpath.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; busy then stays high until the
// cycle in which the single response appears on rsp_data for one cycle with rsp_strobe,
// and the receiver must take it then because it cannot stall. Entries live in a memory
// with one read and one write port, and moving one entry takes a read and then a write,
// so insert and delete time grows with the number of entries behind the position.
// Delete and retrieve first read the entry at the position; replace, clear, unused actions
// and any request that fails its check go from the check straight to the response. The
// next request may be accepted in the same cycle as the strobe.
module positional_list_store #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire plst_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output plst_pkg::rsp_type      rsp_data
);
   import plst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   plst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   plst_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### design/plst_ctrl.sv
// Controller of the positional list store: sequences checks, entry moves and the response.
// Depends on plst_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module plst_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output logic                  rsp_strobe,
   input  wire plst_pkg::stat_type stat,
   output plst_pkg::cmd_type     cmd
);
   import plst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_RD_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      rsp_strobe_ff;

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = RD_AT_INDEX;
      cmd.step       = STEP_HOLD;
      cmd.cnt_op     = CNT_HOLD;
      state_in       = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_DONE;
            if (stat.ok) begin
               case (stat.action)
                  ACT_INSERT: begin
                     state_in = S_SHIFT_RD;
                  end
                  ACT_DELETE, ACT_RETRIEVE: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_AT_INDEX;
                     state_in   = S_RD_WAIT;
                  end
                  ACT_REPLACE: begin
                     cmd.wr_en = 1'b1;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            cmd.save_result = 1'b1;
            state_in = (stat.action == ACT_DELETE) ? S_SHIFT_RD : S_DONE;
         end
         S_SHIFT_RD: begin
            if (stat.action == ACT_INSERT) begin
               if (stat.at_pos) begin
                  cmd.wr_en = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_BELOW_INDEX;
                  state_in   = S_SHIFT_WR;
               end
            end else begin
               if (stat.at_end) begin
                  state_in = S_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ABOVE_INDEX;
                  state_in   = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_from_mem = 1'b1;
            cmd.step        = (stat.action == ACT_INSERT) ? STEP_DEC : STEP_INC;
            state_in        = S_SHIFT_RD;
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
            if (stat.action == ACT_CLEAR) begin
               cmd.cnt_op = CNT_CLEAR;
            end else if (stat.ok && stat.action == ACT_INSERT) begin
               cmd.cnt_op = CNT_INC;
            end else if (stat.ok && stat.action == ACT_DELETE) begin
               cmd.cnt_op = CNT_DEC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= cmd.respond;
         if (cmd.capture) begin
            busy_ff <= 1'b1;
         end else if (cmd.respond) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

`default_nettype wire

### design/plst_dpath.sv
// Datapath of the positional list store: entry memory, count, walk index and response registers.
// Depends on plst_pkg for payload, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module plst_dpath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire plst_pkg::req_type req_data,
   input  wire plst_pkg::cmd_type cmd,
   output plst_pkg::stat_type     stat,
   output plst_pkg::rsp_type      rsp_data
);
   import plst_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W  = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [DATA_WIDTH-1:0] result_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      idx_dec;
   logic [CNT_W-1:0]      idx_inc;
   logic [ACTION_W-1:0]   act_ff;
   logic [POSITION_W-1:0] pos_ff;
   logic [STATUS_W-1:0]   stat_ff;
   logic [STATUS_W-1:0]   stat_in;
   logic [CMP_W-1:0]      req_pos_ext;
   logic [CMP_W-1:0]      count_ext;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   rsp_type               rsp_ff;

   assign req_pos_ext = CMP_W'(req_data.position);
   assign count_ext   = CMP_W'(count_ff);
   assign idx_dec     = idx_ff - CNT_W'(1);
   assign idx_inc     = idx_ff + CNT_W'(1);

   always_comb begin
      stat_in = ST_OK;
      case (req_data.action)
         ACT_INSERT: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               stat_in = ST_FULL;
            end else if (req_pos_ext > count_ext) begin
               stat_in = ST_RANGE;
            end
         end
         ACT_DELETE, ACT_RETRIEVE, ACT_REPLACE: begin
            if (req_pos_ext >= count_ext) begin
               stat_in = ST_RANGE;
            end
         end
         default: begin
            stat_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_BELOW_INDEX: rd_addr = idx_dec[ADDR_W-1:0];
         RD_ABOVE_INDEX: rd_addr = idx_inc[ADDR_W-1:0];
         default:        rd_addr = idx_ff[ADDR_W-1:0];
      endcase
   end

   assign wr_data = cmd.wr_from_mem ? rd_data_ff : val_ff;

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CNT_W'(1);
         CNT_DEC:   count_in = count_ff - CNT_W'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[idx_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff    <= req_data.action;
         pos_ff    <= req_data.position;
         val_ff    <= DATA_WIDTH'(req_data.value_in);
         stat_ff   <= stat_in;
         result_ff <= '0;
         if (req_data.action == ACT_INSERT) begin
            idx_ff <= count_ff;
         end else begin
            idx_ff <= CNT_W'(req_data.position);
         end
      end else begin
         if (cmd.save_result) begin
            result_ff <= rd_data_ff;
         end
         case (cmd.step)
            STEP_DEC: idx_ff <= idx_dec;
            STEP_INC: idx_ff <= idx_inc;
            default:  idx_ff <= idx_ff;
         endcase
      end
      if (cmd.respond) begin
         rsp_ff.value_out <= VALUE_W'(result_ff);
         rsp_ff.status    <= stat_ff;
         rsp_ff.count     <= COUNT_W'(count_in);
         rsp_ff.is_empty  <= (count_in == '0);
         rsp_ff.is_full   <= (count_in == CNT_W'(DEPTH));
      end
   end

   assign stat.action = act_ff;
   assign stat.ok     = (stat_ff == ST_OK);
   assign stat.at_pos = (CMP_W'(idx_ff) == CMP_W'(pos_ff));
   assign stat.at_end = (idx_inc >= count_ff);
   assign rsp_data    = rsp_ff;

endmodule

`default_nettype wire

### design/plst_checker.sv
// Port-level checks for the positional list store, bound to the top level.
// Depends on plst_pkg and positional_list_store.
`timescale 1ns / 1ps
`default_nettype none

module plst_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire plst_pkg::rsp_type rsp_data
);
   import plst_pkg::*;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   a_idle_with_response: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while still busy");

   a_single_response: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_FULL) |-> rsp_data.is_full)
      else $error("full status reported on a list that is not full");

   a_failed_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.value_out == '0))
      else $error("failed request returned a nonzero value");

endmodule

bind positional_list_store plst_checker u_plst_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
